[rtl/bsec_pkg.sv]
// ----------------------------------------------------------------------------
// bsec_pkg: shared types and constants of the byte stuffing codec
// Frame bytes, register map and the result record passed to the output queue.
// ----------------------------------------------------------------------------
package bsec_pkg;

	// Special bytes of the frame format
	localparam logic [7:0] DELIM_BYTE = 8'hFF;
	localparam logic [7:0] ESC_BYTE   = 8'hFE;
	localparam logic [7:0] ESC_DELIM  = 8'hFD;
	localparam logic [7:0] ESC_ESC    = 8'hFC;

	// Register map
	localparam int unsigned ADDR_W   = 1;
	localparam logic [ADDR_W-1:0] REG_MODE = 1'b0;

	// Codec mode
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// One output item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       frame_end;
	} res_t;

	// Up to two output items produced by one input item
	typedef struct packed {
		logic push0;
		logic push1;
		res_t res0;
		res_t res1;
	} res_pair_t;

endpackage

[rtl/byte_stuffing_escape_codec.sv]
// ----------------------------------------------------------------------------
// byte_stuffing_escape_codec: 0xFF/0xFE byte stuffing encoder and decoder
// Encode escapes FF as FE FD and FE as FE FC; decode undoes it.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake           Payload
// s        in   s_tvalid/s_tready   s_tdata = data_byte, s_tlast = buffer_end
// m        out  m_tvalid/m_tready   m_tdata = out_byte, m_tuser = run_end,
//                                   m_tlast = frame_end
// cfg      in   psel/penable/pready register 0 at address 0: mode
//
// One input item per cycle while s_tready is high: an item is held in the
// input register, then lands in a four-entry output queue, and m_tvalid rises
// once the item is written into the queue. Items that expand to two bytes are
// drained at one byte per cycle while m_tready is high, so a run of them takes
// input at half rate, set by the single queue read port. s_tready drops while
// the input register is full and the queue holds more than two items. Reset
// clears the queue, the input register, mode and the pending escape; a write
// to mode also drops a pending escape.
// ----------------------------------------------------------------------------
module byte_stuffing_escape_codec (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bsec_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// Input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] data_byte
	input  logic                          s_tlast,
	// Output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] out_byte
	output logic                          m_tuser,   // [0] run_end
	output logic                          m_tlast
);
	import bsec_pkg::*;

	logic      mode_q;
	logic      mode_wr;
	logic      room;
	res_pair_t wr;
	res_t      head;

	// Register write and read-back
	assign pready  = 1'b1;
	assign mode_wr = psel & penable & pwrite & pready & (paddr == REG_MODE);
	assign prdata  = (paddr == REG_MODE) ? {31'b0, mode_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENCODE;
		end else if (mode_wr) begin
			mode_q <= pwdata[0];
		end
	end

	bsec_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode_q),
		.clr_pending (mode_wr),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.room        (room),
		.wr          (wr)
	);

	bsec_ofifo u_ofifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head     (head)
	);

	// Present the queue head
	assign m_tdata = head.out_byte;
	assign m_tuser = head.run_end;
	assign m_tlast = head.frame_end;

endmodule

[rtl/bsec_core.sv]
// ----------------------------------------------------------------------------
// bsec_core: input register and escape encode/decode logic
// Holds one input item, turns it into zero, one or two output items and
// keeps the pending-escape flag of the decoder.
// ----------------------------------------------------------------------------
module bsec_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               mode,
	input  logic               clr_pending,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,
	input  logic               s_tlast,
	input  logic               room,
	output bsec_pkg::res_pair_t wr
);
	import bsec_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       pending_q;
	logic       go;
	logic [1:0] cnt;
	logic [7:0] b0;
	logic [7:0] b1;
	logic       pend_nxt;

	assign go       = valid_s1 & room;
	assign s_tready = ~valid_s1 | room;

	// Capture the input item; advance when the queue can take two items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Work out the output bytes and the next pending flag
	always_comb begin
		cnt      = 2'd1;
		b0       = byte_s1;
		b1       = byte_s1;
		pend_nxt = pending_q;
		if (mode == MODE_ENCODE) begin
			if (byte_s1 == DELIM_BYTE) begin
				cnt = 2'd2;
				b0  = ESC_BYTE;
				b1  = ESC_DELIM;
			end else if (byte_s1 == ESC_BYTE) begin
				cnt = 2'd2;
				b0  = ESC_BYTE;
				b1  = ESC_ESC;
			end
		end else if (pending_q) begin
			pend_nxt = 1'b0;
			if (byte_s1 == ESC_DELIM) begin
				b0 = DELIM_BYTE;
			end else if (byte_s1 == ESC_ESC) begin
				b0 = ESC_BYTE;
			end else if (byte_s1 == ESC_BYTE && !last_s1) begin
				// held escape goes out literally, this one is held instead
				b0       = ESC_BYTE;
				pend_nxt = 1'b1;
			end else begin
				cnt = 2'd2;
				b0  = ESC_BYTE;
				b1  = byte_s1;
			end
		end else if (byte_s1 == ESC_BYTE && !last_s1) begin
			cnt      = 2'd0;
			pend_nxt = 1'b1;
		end
	end

	// Hold the decoder's pending escape
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (clr_pending) begin
			pending_q <= 1'b0;
		end else if (go) begin
			pending_q <= pend_nxt;
		end
	end

	// Queue write request; the last item of the pair carries the flags
	always_comb begin
		wr.push0           = go & (cnt != 2'd0);
		wr.push1           = go & (cnt == 2'd2);
		wr.res0.out_byte   = b0;
		wr.res0.run_end    = (cnt == 2'd1);
		wr.res0.frame_end  = (cnt == 2'd1) & last_s1;
		wr.res1.out_byte   = b1;
		wr.res1.run_end    = 1'b1;
		wr.res1.frame_end  = last_s1;
	end

endmodule

[rtl/bsec_ofifo.sv]
// ----------------------------------------------------------------------------
// bsec_ofifo: four-entry output queue
// Takes up to two items per cycle, presents one item per cycle downstream while m_tready is high.
// ----------------------------------------------------------------------------
module bsec_ofifo (
	input  logic                clk,
	input  logic                arst_n,
	input  bsec_pkg::res_pair_t wr,
	output logic                room,
	output logic                m_tvalid,
	input  logic                m_tready,
	output bsec_pkg::res_t      head
);
	import bsec_pkg::*;

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(DEPTH);

	res_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W:0]   count_q;
	logic             pop;
	logic [PTR_W-1:0] wp_inc;
	logic [PTR_W:0]   n_push;

	assign pop      = m_tvalid & m_tready;
	assign m_tvalid = (count_q != '0);
	assign head     = mem_q[rp_q];
	assign room     = (count_q <= (PTR_W+1)'(DEPTH - 2));
	assign wp_inc   = wp_q + PTR_W'(1);
	assign n_push   = (PTR_W+1)'(wr.push0) + (PTR_W+1)'(wr.push1);

	// Store pushed items
	always_ff @(posedge clk) begin
		if (wr.push0) begin
			mem_q[wp_q] <= wr.res0;
		end
		if (wr.push1) begin
			mem_q[wp_inc] <= wr.res1;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + PTR_W'(n_push);
			rp_q    <= rp_q + PTR_W'(pop);
			count_q <= count_q + n_push - (PTR_W+1)'(pop);
		end
	end

endmodule
